[rtl/partitioned_burst_slot_ring_core_assert.svh]
// assertion macros used by the core rtl of the burst slot ring
// each macro checks one implication on the rising clock edge, masked while reset is low
// nothing here depends on the package or on any module
`ifndef PARTITIONED_BURST_SLOT_RING_CORE_ASSERT_SVH
`define PARTITIONED_BURST_SLOT_RING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PBSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PBSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define PBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/pbsr_pkg.sv]
// constants, codes and helper functions of the partitioned burst slot ring
// used by the slot ring core; no dependencies
`default_nettype none

package pbsr_pkg;

  localparam int THREADS          = 4;
  localparam int SLOTS_PER_THREAD = 16;
  localparam int MAX_BURST        = 64;

  localparam int RING_SLOTS = THREADS * SLOTS_PER_THREAD;

  // field widths of the item ports
  localparam int ACT_W      = 3;
  localparam int THR_IN_W   = 2;
  localparam int CNT_W      = 7;
  localparam int IDX_OUT_W  = 6;
  localparam int ST_W       = 2;

  // internal widths
  localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int TW1 = TW + 1;
  localparam int OW  = (SLOTS_PER_THREAD > 1) ? $clog2(SLOTS_PER_THREAD) : 1;
  localparam int SW  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHOOSE_RX    = 3'd0,
    ACT_COMMIT_RX    = 3'd1,
    ACT_PROC_QUERY   = 3'd2,
    ACT_PROC_DONE    = 3'd3,
    ACT_CHOOSE_DRAIN = 3'd4,
    ACT_CLEAN        = 3'd5
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_FREE       = 2'd0,
    ST_PROCESSING = 2'd1,
    ST_DONE       = 2'd2
  } slot_state_t;

  // thread number from the port, reduced modulo the thread count
  function automatic logic [TW-1:0] thr_reduce(input logic [THR_IN_W-1:0] v);
    logic [THR_IN_W-1:0] r;
    r = v;
    for (int k = 0; k < 4; k++) begin
      if (32'(r) >= THREADS) begin
        r = r - THR_IN_W'(THREADS);
      end
    end
    return TW'(r);
  endfunction

  // wrap a sum below twice the thread count
  function automatic logic [TW-1:0] thr_wrap(input logic [TW1-1:0] v);
    logic [TW1-1:0] r;
    r = v;
    if (32'(v) >= THREADS) begin
      r = v - TW1'(THREADS);
    end
    return TW'(r);
  endfunction

  // absolute slot of a thread's subring offset
  function automatic logic [SW-1:0] slot_of(input logic [TW-1:0] thr,
                                            input logic [OW-1:0] off);
    return SW'(SW'(thr) * SW'(SLOTS_PER_THREAD) + SW'(off));
  endfunction

  // circular advance within a subring
  function automatic logic [OW-1:0] next_off(input logic [OW-1:0] off);
    logic [OW-1:0] r;
    r = OW'(off + 1'b1);
    if (32'(off) == SLOTS_PER_THREAD - 1) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/pbsr_ram.sv]
// generic single write port, single read port ram with registered read data
// standalone; used for the slot state and slot count stores
`default_nettype none

module pbsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/partitioned_burst_slot_ring_core.sv]
// partitioned burst slot ring: six slot operations over per-thread subrings
// depends on pbsr_pkg, pbsr_ram and the assertion macro header
// an accepted item sweeps the drain pointer of every thread, then for choose receive the
//   receive pointer of every thread or for process query one slot, then evaluates and
//   finishes; one slot state read per cycle through the single read port of the state ram;
//   no new item is taken until finish, waiting for a free output, has loaded the result
// reset: synchronous, active low; offsets and slot valid bits clear, with no clearing
//   pass; the count ram is not cleared
`default_nettype none

`include "partitioned_burst_slot_ring_core_assert.svh"

module partitioned_burst_slot_ring_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // item input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pbsr_pkg::ACT_W-1:0]        in_action,
  input  wire logic [pbsr_pkg::THR_IN_W-1:0]     in_thread,
  input  wire logic [pbsr_pkg::CNT_W-1:0]        in_packet_count,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_found,
  output logic      [pbsr_pkg::THR_IN_W-1:0]     out_chosen_thread,
  output logic      [pbsr_pkg::IDX_OUT_W-1:0]    out_slot_index,
  output logic      [pbsr_pkg::CNT_W-1:0]        out_slot_packets,
  output logic                                   out_is_ready,
  output logic                                   out_is_empty,
  output logic                                   out_all_drained
);

  // idle -> drain sweep -> op sweep (choose receive, process query) -> last eval -> finish
  typedef enum logic [2:0] {
    S_IDLE,
    S_DRN,
    S_OPR,
    S_LAST,
    S_FIN
  } fsm_t;

  // what a pending ram read is for
  typedef enum logic [1:0] {
    RD_DRAIN,
    RD_RECV,
    RD_PROC
  } rd_kind_t;

  fsm_t state_r, state_nxt;

  // item context
  pbsr_pkg::action_t            act_r, act_nxt;
  logic [pbsr_pkg::TW-1:0]      thr_r, thr_nxt;
  logic [pbsr_pkg::OW-1:0]      adv_off_r, adv_off_nxt;
  logic [pbsr_pkg::TW-1:0]      cnt_r, cnt_nxt;

  // pending read tag, registered with the ram address so it lines up with the read data
  logic                         rd_pend_r, rd_pend_nxt;
  rd_kind_t                     rd_kind_r, rd_kind_nxt;
  logic [pbsr_pkg::TW-1:0]      rd_thr_r, rd_thr_nxt;
  logic [pbsr_pkg::SW-1:0]      rd_slot_r, rd_slot_nxt;

  // result accumulators
  logic                         found_r, found_nxt;
  logic [pbsr_pkg::TW-1:0]      chosen_r, chosen_nxt;
  logic [pbsr_pkg::SW-1:0]      idx_r, idx_nxt;
  logic [pbsr_pkg::CNT_W-1:0]   pk_r, pk_nxt;
  logic                         ready_r, ready_nxt;
  logic                         empty_r, empty_nxt;
  logic                         drained_r, drained_nxt;

  // per-thread subring offsets
  logic [pbsr_pkg::OW-1:0]      rcv_off_r [pbsr_pkg::THREADS];
  logic [pbsr_pkg::OW-1:0]      rcv_off_nxt [pbsr_pkg::THREADS];
  logic [pbsr_pkg::OW-1:0]      prc_off_r [pbsr_pkg::THREADS];
  logic [pbsr_pkg::OW-1:0]      prc_off_nxt [pbsr_pkg::THREADS];
  logic [pbsr_pkg::OW-1:0]      drn_off_r [pbsr_pkg::THREADS];
  logic [pbsr_pkg::OW-1:0]      drn_off_nxt [pbsr_pkg::THREADS];

  // slot written since reset; an unwritten slot reads as free
  logic [pbsr_pkg::RING_SLOTS-1:0] vld_r, vld_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [pbsr_pkg::THR_IN_W-1:0]  out_chosen_r, out_chosen_nxt;
  logic [pbsr_pkg::IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic [pbsr_pkg::CNT_W-1:0]   out_pk_r, out_pk_nxt;
  logic                         out_ready_r, out_ready_nxt;
  logic                         out_empty_r, out_empty_nxt;
  logic                         out_drained_r, out_drained_nxt;

  // ram ports
  logic                         rd_en;
  logic [pbsr_pkg::SW-1:0]      rd_addr;
  logic                         st_we;
  logic [pbsr_pkg::ST_W-1:0]    st_wdata;
  logic                         cnt_we;
  logic [pbsr_pkg::ST_W-1:0]    st_q;
  logic [pbsr_pkg::CNT_W-1:0]   cnt_q;

  // scan and lookup helpers
  logic [pbsr_pkg::TW-1:0]      t_in;
  logic [pbsr_pkg::TW-1:0]      c_iss;
  logic [pbsr_pkg::TW-1:0]      off_addr;
  logic [pbsr_pkg::OW-1:0]      rcv_off_rd;
  logic [pbsr_pkg::OW-1:0]      prc_off_rd;
  logic [pbsr_pkg::OW-1:0]      drn_off_rd;
  logic [pbsr_pkg::ST_W-1:0]    st_rd;
  logic [pbsr_pkg::CNT_W-1:0]   pc_sat;
  logic                         in_acc;
  logic                         out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_chosen_thread = out_chosen_r;
  assign out_slot_index    = out_idx_r;
  assign out_slot_packets  = out_pk_r;
  assign out_is_ready      = out_ready_r;
  assign out_is_empty      = out_empty_r;
  assign out_all_drained   = out_drained_r;

  assign t_in = pbsr_pkg::thr_reduce(in_thread);

  // commit saturates the burst size
  assign pc_sat = (in_packet_count > pbsr_pkg::MAX_BURST) ?
                  pbsr_pkg::CNT_W'(pbsr_pkg::MAX_BURST) : in_packet_count;

  // thread visited by the sweep this cycle: the drain sweep starts one past the
  // addressed thread, the receive sweep at the addressed thread itself
  always_comb begin
    c_iss = thr_r;
    if (state_r == S_DRN) begin
      c_iss = pbsr_pkg::thr_wrap({1'b0, thr_r} + pbsr_pkg::TW1'(1) + {1'b0, cnt_r});
    end else if (state_r == S_OPR && act_r == pbsr_pkg::ACT_CHOOSE_RX) begin
      c_iss = pbsr_pkg::thr_wrap({1'b0, thr_r} + {1'b0, cnt_r});
    end
  end

  // one lookup into the offset tables: the incoming thread on accept, else the sweep
  assign off_addr   = (state_r == S_IDLE) ? t_in : c_iss;
  assign rcv_off_rd = rcv_off_r[off_addr];
  assign prc_off_rd = prc_off_r[off_addr];
  assign drn_off_rd = drn_off_r[off_addr];

  // state of the slot read last cycle
  assign st_rd = vld_r[rd_slot_r] ? st_q : pbsr_pkg::ST_W'(pbsr_pkg::ST_FREE);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    thr_nxt         = thr_r;
    adv_off_nxt     = adv_off_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    chosen_nxt      = chosen_r;
    idx_nxt         = idx_r;
    pk_nxt          = pk_r;
    ready_nxt       = ready_r;
    empty_nxt       = empty_r;
    drained_nxt     = drained_r;
    rcv_off_nxt     = rcv_off_r;
    prc_off_nxt     = prc_off_r;
    drn_off_nxt     = drn_off_r;
    vld_nxt         = vld_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_found_nxt   = out_found_r;
    out_chosen_nxt  = out_chosen_r;
    out_idx_nxt     = out_idx_r;
    out_pk_nxt      = out_pk_r;
    out_ready_nxt   = out_ready_r;
    out_empty_nxt   = out_empty_r;
    out_drained_nxt = out_drained_r;
    rd_en           = 1'b0;
    rd_addr         = pbsr_pkg::slot_of(c_iss, drn_off_rd);
    rd_kind_nxt     = RD_DRAIN;
    st_we           = 1'b0;
    st_wdata        = pbsr_pkg::ST_W'(pbsr_pkg::ST_FREE);
    cnt_we          = 1'b0;

    // evaluate the slot read issued last cycle
    if (rd_pend_r) begin
      unique case (rd_kind_r)
        RD_DRAIN: begin
          if (st_rd != pbsr_pkg::ST_FREE) begin
            drained_nxt = 1'b0;
          end
          // first done slot in sweep order wins
          if (act_r == pbsr_pkg::ACT_CHOOSE_DRAIN && !found_r &&
              st_rd == pbsr_pkg::ST_DONE) begin
            found_nxt  = 1'b1;
            chosen_nxt = rd_thr_r;
            idx_nxt    = rd_slot_r;
            pk_nxt     = cnt_q;
          end
          // clean reports the count unless the slot was already free
          if (act_r == pbsr_pkg::ACT_CLEAN && rd_thr_r == thr_r &&
              st_rd != pbsr_pkg::ST_FREE) begin
            pk_nxt = cnt_q;
          end
        end
        RD_RECV: begin
          if (!found_r && st_rd == pbsr_pkg::ST_FREE) begin
            found_nxt  = 1'b1;
            chosen_nxt = rd_thr_r;
            idx_nxt    = rd_slot_r;
          end
        end
        RD_PROC: begin
          ready_nxt = (st_rd == pbsr_pkg::ST_PROCESSING);
          empty_nxt = (st_rd == pbsr_pkg::ST_FREE);
          pk_nxt    = (st_rd == pbsr_pkg::ST_PROCESSING) ? cnt_q : '0;
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt     = pbsr_pkg::action_t'(in_action);
          thr_nxt     = t_in;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          chosen_nxt  = t_in;
          pk_nxt      = '0;
          ready_nxt   = 1'b0;
          empty_nxt   = 1'b0;
          drained_nxt = 1'b1;
          // default slot is the addressed thread's pointer for this action
          unique case (pbsr_pkg::action_t'(in_action))
            pbsr_pkg::ACT_CHOOSE_RX: begin
              adv_off_nxt = rcv_off_rd;
              idx_nxt     = pbsr_pkg::slot_of(t_in, rcv_off_rd);
            end
            pbsr_pkg::ACT_COMMIT_RX: begin
              adv_off_nxt = rcv_off_rd;
              idx_nxt     = pbsr_pkg::slot_of(t_in, rcv_off_rd);
              pk_nxt      = pc_sat;
            end
            pbsr_pkg::ACT_PROC_QUERY,
            pbsr_pkg::ACT_PROC_DONE: begin
              adv_off_nxt = prc_off_rd;
              idx_nxt     = pbsr_pkg::slot_of(t_in, prc_off_rd);
            end
            pbsr_pkg::ACT_CHOOSE_DRAIN,
            pbsr_pkg::ACT_CLEAN: begin
              adv_off_nxt = drn_off_rd;
              idx_nxt     = pbsr_pkg::slot_of(t_in, drn_off_rd);
            end
            default: begin
              adv_off_nxt = '0;
              idx_nxt     = '0;
            end
          endcase
          state_nxt = S_DRN;
        end
      end

      // drain pointer of every thread: all-drained, choose drain and clean
      S_DRN: begin
        rd_en       = 1'b1;
        rd_addr     = pbsr_pkg::slot_of(c_iss, drn_off_rd);
        rd_kind_nxt = RD_DRAIN;
        if (32'(cnt_r) == pbsr_pkg::THREADS - 1) begin
          cnt_nxt = '0;
          if (act_r == pbsr_pkg::ACT_CHOOSE_RX || act_r == pbsr_pkg::ACT_PROC_QUERY) begin
            state_nxt = S_OPR;
          end else begin
            state_nxt = S_LAST;
          end
        end else begin
          cnt_nxt = pbsr_pkg::TW'(cnt_r + 1'b1);
        end
      end

      // receive pointers for choose receive, or one process slot for a query
      S_OPR: begin
        rd_en = 1'b1;
        if (act_r == pbsr_pkg::ACT_PROC_QUERY) begin
          rd_addr     = pbsr_pkg::slot_of(thr_r, prc_off_rd);
          rd_kind_nxt = RD_PROC;
        end else begin
          rd_addr     = pbsr_pkg::slot_of(c_iss, rcv_off_rd);
          rd_kind_nxt = RD_RECV;
        end
        if (act_r == pbsr_pkg::ACT_PROC_QUERY ||
            32'(cnt_r) == pbsr_pkg::THREADS - 1) begin
          cnt_nxt   = '0;
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = pbsr_pkg::TW'(cnt_r + 1'b1);
        end
      end

      // last read evaluates here
      S_LAST: begin
        state_nxt = S_FIN;
      end

      // write back slot and pointer for commit, process done and clean, load the result; waits for a free output
      S_FIN: begin
        if (out_free) begin
          unique case (act_r)
            pbsr_pkg::ACT_COMMIT_RX: begin
              st_we              = 1'b1;
              st_wdata           = pbsr_pkg::ST_W'(pbsr_pkg::ST_PROCESSING);
              cnt_we             = 1'b1;
              rcv_off_nxt[thr_r] = pbsr_pkg::next_off(adv_off_r);
            end
            pbsr_pkg::ACT_PROC_DONE: begin
              st_we              = 1'b1;
              st_wdata           = pbsr_pkg::ST_W'(pbsr_pkg::ST_DONE);
              prc_off_nxt[thr_r] = pbsr_pkg::next_off(adv_off_r);
            end
            pbsr_pkg::ACT_CLEAN: begin
              st_we              = 1'b1;
              st_wdata           = pbsr_pkg::ST_W'(pbsr_pkg::ST_FREE);
              drn_off_nxt[thr_r] = pbsr_pkg::next_off(adv_off_r);
            end
            default: begin
            end
          endcase
          if (st_we) begin
            vld_nxt[idx_r] = 1'b1;
          end
          out_valid_nxt   = 1'b1;
          out_found_nxt   = found_r;
          out_chosen_nxt  = pbsr_pkg::THR_IN_W'(chosen_r);
          out_idx_nxt     = pbsr_pkg::IDX_OUT_W'(idx_r);
          out_pk_nxt      = pk_r;
          out_ready_nxt   = ready_r;
          out_empty_nxt   = empty_r;
          out_drained_nxt = drained_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_pend_nxt = rd_en;
    rd_thr_nxt  = c_iss;
    rd_slot_nxt = rd_addr;
  end

  always_ff @(posedge clk) begin
    // payload, no reset
    act_r          <= act_nxt;
    thr_r          <= thr_nxt;
    adv_off_r      <= adv_off_nxt;
    rd_kind_r      <= rd_kind_nxt;
    rd_thr_r       <= rd_thr_nxt;
    rd_slot_r      <= rd_slot_nxt;
    found_r        <= found_nxt;
    chosen_r       <= chosen_nxt;
    idx_r          <= idx_nxt;
    pk_r           <= pk_nxt;
    ready_r        <= ready_nxt;
    empty_r        <= empty_nxt;
    drained_r      <= drained_nxt;
    out_found_r    <= out_found_nxt;
    out_chosen_r   <= out_chosen_nxt;
    out_idx_r      <= out_idx_nxt;
    out_pk_r       <= out_pk_nxt;
    out_ready_r    <= out_ready_nxt;
    out_empty_r    <= out_empty_nxt;
    out_drained_r  <= out_drained_nxt;
    // control
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      for (int i = 0; i < pbsr_pkg::THREADS; i++) begin
        rcv_off_r[i] <= '0;
        prc_off_r[i] <= '0;
        drn_off_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      rcv_off_r   <= rcv_off_nxt;
      prc_off_r   <= prc_off_nxt;
      drn_off_r   <= drn_off_nxt;
    end
  end

  // slot state store, written only at finish so reads never overlap a write
  pbsr_ram #(
    .WIDTH (pbsr_pkg::ST_W),
    .DEPTH (pbsr_pkg::RING_SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx_r),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_q)
  );

  // packet count store, written by commit, read alongside the state
  pbsr_ram #(
    .WIDTH (pbsr_pkg::CNT_W),
    .DEPTH (pbsr_pkg::RING_SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx_r),
    .wdata (pk_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_q)
  );

  `PBSR_ASSERT_NEXT(a_accept_starts_sweep, clk, rst_n, in_acc, state_r == S_DRN, "accepted item did not start the drain sweep")
  `PBSR_ASSERT_IMP(a_write_only_at_finish, clk, rst_n, st_we, (state_r == S_FIN) && !rd_en, "slot write outside finish or during a read")
  `PBSR_ASSERT_IMP(a_chosen_in_range, clk, rst_n, out_valid_r, 32'(out_chosen_thread) < pbsr_pkg::THREADS, "chosen thread out of range")
  `PBSR_ASSERT_IMP(a_ready_empty_excl, clk, rst_n, out_valid_r, !(out_is_ready && out_is_empty), "slot both ready and empty")

endmodule

`default_nettype wire
